// File: hdl/mpct_pkg.sv
// shared types and constants for the mouse packet cursor tracker
package mpct_pkg;

   localparam int ByteW   = 8;
   localparam int ScreenW = 13;
   localparam int ThreshW = 7;
   localparam int ModeW   = 2;
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;

   localparam logic [ScreenW-1:0] WidthReset  = 13'd1024;
   localparam logic [ScreenW-1:0] HeightReset = 13'd768;
   localparam logic [ThreshW-1:0] ThreshReset = 7'd3;

   typedef enum logic [1:0] {
      REG_SCREEN_WIDTH  = 2'd0,
      REG_SCREEN_HEIGHT = 2'd1,
      REG_ACCEL_THRESH  = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   typedef enum logic [ModeW-1:0] {
      DRAG_NONE   = 2'd0,
      DRAG_MOVE   = 2'd1,
      DRAG_RESIZE = 2'd2,
      DRAG_ALIAS  = 2'd3
   } drag_mode_type;

   typedef struct packed {
      logic left_press;
      logic left_release;
      logic right_press;
      logic right_release;
      logic end_drag;
   } button_flags_type;

endpackage

// File: hdl/mouse_packet_cursor_tracker.sv
// top level: input register, axis and button logic, result register, csr block
// an accepted item is held in the input register, and its result then in the result register
// throughput: one item per cycle unless a result waits on rsp_ready, set by the single compute stage between registers
// the result register updates the cursor state, so a following item sees it at once
// reset (synchronous, active high) empties both stages, zeroes cursor and buttons
// and loads the screen size and threshold registers with their defaults
module mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mpct_pkg::ByteW-1:0]     req_status_byte,
   input  logic [mpct_pkg::ByteW-1:0]     req_dx_byte,
   input  logic [mpct_pkg::ByteW-1:0]     req_dy_byte,
   input  logic [mpct_pkg::ModeW-1:0]     req_drag_mode,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [COORD_BITS-1:0]          rsp_cursor_x,
   output logic [COORD_BITS-1:0]          rsp_cursor_y,
   output logic                           rsp_moved,
   output logic                           rsp_left_press,
   output logic                           rsp_left_release,
   output logic                           rsp_right_press,
   output logic                           rsp_right_release,
   output logic                           rsp_end_drag,
   output logic [mpct_pkg::ByteW-1:0]     rsp_buttons,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mpct_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [mpct_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [mpct_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                           csr_pready
);

   logic [mpct_pkg::ScreenW-1:0] width_ff, width_in;
   logic [mpct_pkg::ScreenW-1:0] height_ff, height_in;
   logic [mpct_pkg::ThreshW-1:0] thresh_ff, thresh_in;

   logic                         in_valid_ff, in_valid_in;
   logic [mpct_pkg::ByteW-1:0]   status_ff, status_in;
   logic [mpct_pkg::ByteW-1:0]   dx_ff, dx_in;
   logic [mpct_pkg::ByteW-1:0]   dy_ff, dy_in;
   logic [mpct_pkg::ModeW-1:0]   mode_ff, mode_in;

   logic                         out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]        pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]        pos_y_ff, pos_y_in;
   logic [mpct_pkg::ByteW-1:0]   prev_buttons_ff, prev_buttons_in;
   logic                         moved_ff, moved_in;
   mpct_pkg::button_flags_type   flags_ff, flags_in;

   logic                         csr_write;
   mpct_pkg::reg_index_type      csr_index;
   logic                         advance;
   logic                         req_accept;
   logic [COORD_BITS-1:0]        new_x;
   logic [COORD_BITS-1:0]        new_y;
   mpct_pkg::button_flags_type   flags;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_index  = mpct_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      csr_prdata = '0;
      unique case (csr_index)
         mpct_pkg::REG_SCREEN_WIDTH: begin
            csr_prdata = mpct_pkg::CsrDataW'(width_ff);
            if (csr_write) width_in = csr_pwdata[mpct_pkg::ScreenW-1:0];
         end
         mpct_pkg::REG_SCREEN_HEIGHT: begin
            csr_prdata = mpct_pkg::CsrDataW'(height_ff);
            if (csr_write) height_in = csr_pwdata[mpct_pkg::ScreenW-1:0];
         end
         mpct_pkg::REG_ACCEL_THRESH: begin
            csr_prdata = mpct_pkg::CsrDataW'(thresh_ff);
            if (csr_write) thresh_in = csr_pwdata[mpct_pkg::ThreshW-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // pipeline control
   assign advance    = ~out_valid_ff | rsp_ready;
   assign req_ready  = ~in_valid_ff | advance;
   assign req_accept = req_valid & req_ready;

   mpct_axis #(.CoordBits(COORD_BITS)) u_axis_x (
      .delta_byte      (dx_ff),
      .accel_threshold (thresh_ff),
      .pos             (pos_x_ff),
      .limit           (width_ff),
      .subtract        (1'b0),
      .coord           (new_x)
   );

   mpct_axis #(.CoordBits(COORD_BITS)) u_axis_y (
      .delta_byte      (dy_ff),
      .accel_threshold (thresh_ff),
      .pos             (pos_y_ff),
      .limit           (height_ff),
      .subtract        (1'b1),
      .coord           (new_y)
   );

   mpct_buttons u_buttons (
      .status_byte  (status_ff),
      .prev_buttons (prev_buttons_ff),
      .drag_mode    (mode_ff),
      .flags        (flags)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      status_in   = status_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      mode_in     = mode_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         status_in   = req_status_byte;
         dx_in       = req_dx_byte;
         dy_in       = req_dy_byte;
         mode_in     = req_drag_mode;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in    = out_valid_ff;
      pos_x_in        = pos_x_ff;
      pos_y_in        = pos_y_ff;
      prev_buttons_in = prev_buttons_ff;
      moved_in        = moved_ff;
      flags_in        = flags_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            pos_x_in        = new_x;
            pos_y_in        = new_y;
            prev_buttons_in = status_ff;
            moved_in        = (new_x != pos_x_ff) | (new_y != pos_y_ff);
            flags_in        = flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff        <= mpct_pkg::WidthReset;
         height_ff       <= mpct_pkg::HeightReset;
         thresh_ff       <= mpct_pkg::ThreshReset;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         pos_x_ff        <= '0;
         pos_y_ff        <= '0;
         prev_buttons_ff <= '0;
      end else begin
         width_ff        <= width_in;
         height_ff       <= height_in;
         thresh_ff       <= thresh_in;
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         pos_x_ff        <= pos_x_in;
         pos_y_ff        <= pos_y_in;
         prev_buttons_ff <= prev_buttons_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      mode_ff   <= mode_in;
      moved_ff  <= moved_in;
      flags_ff  <= flags_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_cursor_x      = pos_x_ff;
   assign rsp_cursor_y      = pos_y_ff;
   assign rsp_moved         = moved_ff;
   assign rsp_left_press    = flags_ff.left_press;
   assign rsp_left_release  = flags_ff.left_release;
   assign rsp_right_press   = flags_ff.right_press;
   assign rsp_right_release = flags_ff.right_release;
   assign rsp_end_drag      = flags_ff.end_drag;
   assign rsp_buttons       = prev_buttons_ff;

endmodule

// File: hdl/mpct_axis.sv
// one axis: delta decode, acceleration, position update and screen clamp
module mpct_axis #(
   parameter int CoordBits = 12
) (
   input  logic [mpct_pkg::ByteW-1:0]   delta_byte,
   input  logic [mpct_pkg::ThreshW-1:0] accel_threshold,
   input  logic [CoordBits-1:0]         pos,
   input  logic [mpct_pkg::ScreenW-1:0] limit,
   input  logic                         subtract,
   output logic [CoordBits-1:0]         coord
);

   localparam int SumW = ((CoordBits > 10) ? CoordBits : 10) + 2;
   localparam int CmpW = (SumW > 14) ? SumW : 14;
   localparam logic [CmpW-1:0] Span = CmpW'(1) << CoordBits;

   logic                    neg;
   logic [7:0]              mag;
   logic [9:0]              mag3;
   logic [8:0]              mag_acc;
   logic                    toward_neg;
   logic [SumW-1:0]         pos_ext;
   logic [SumW-1:0]         mag_ext;
   logic signed [SumW-1:0]  sum;
   logic signed [CmpW-1:0]  v;
   logic [CmpW-1:0]         lim_ext;
   logic [CmpW-1:0]         eff;

   always_comb begin
      neg = delta_byte[7];
      mag = neg ? 8'(9'h100 - {1'b0, delta_byte}) : delta_byte;
      mag3 = {2'b00, mag} + {1'b0, mag, 1'b0};
      if (mag > {1'b0, accel_threshold}) begin
         mag_acc = {1'b0, mag} + mag3[9:1];
      end else begin
         mag_acc = {1'b0, mag};
      end
      toward_neg = neg ^ subtract;
      pos_ext = SumW'(pos);
      mag_ext = SumW'(mag_acc);
      sum = toward_neg ? $signed(pos_ext - mag_ext) : $signed(pos_ext + mag_ext);
      v = CmpW'(sum);
      lim_ext = CmpW'(limit);
      eff = (lim_ext > Span) ? Span : lim_ext;
      if (v[CmpW-1] || (eff == '0)) begin
         coord = '0;
      end else if (v >= $signed(eff)) begin
         coord = CoordBits'(eff - CmpW'(1));
      end else begin
         coord = v[CoordBits-1:0];
      end
   end

endmodule

// File: hdl/mpct_buttons.sv
// button edge detection and drag end flag
module mpct_buttons (
   input  logic [mpct_pkg::ByteW-1:0] status_byte,
   input  logic [mpct_pkg::ByteW-1:0] prev_buttons,
   input  logic [mpct_pkg::ModeW-1:0] drag_mode,
   output mpct_pkg::button_flags_type flags
);

   logic in_drag;

   always_comb begin
      unique case (drag_mode)
         mpct_pkg::DRAG_MOVE,
         mpct_pkg::DRAG_RESIZE: in_drag = 1'b1;
         default:               in_drag = 1'b0;
      endcase
      flags = '0;
      priority if (in_drag) begin
         flags.end_drag = ~status_byte[0];
      end else if (prev_buttons[0]) begin
         flags.left_release = ~status_byte[0];
      end else if (prev_buttons[1]) begin
         flags.right_release = ~status_byte[1];
      end else begin
         flags.left_press  = status_byte[0];
         flags.right_press = status_byte[1];
      end
   end

endmodule

// File: hdl/mpct_checker.sv
// port level checks for the cursor tracker, bound to the top level
module mpct_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [COORD_BITS-1:0]          rsp_cursor_x,
   input logic [COORD_BITS-1:0]          rsp_cursor_y,
   input logic                           rsp_moved,
   input logic                           rsp_left_press,
   input logic                           rsp_left_release,
   input logic                           rsp_right_press,
   input logic                           rsp_right_release,
   input logic                           rsp_end_drag,
   input logic [mpct_pkg::ByteW-1:0]     rsp_buttons
);

   // stalled item stays valid and holds its cursor, buttons and moved flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_x)
         && $stable(rsp_cursor_y) && $stable(rsp_buttons) && $stable(rsp_moved))
      else $error("stalled result item changed");

   // no item right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid after reset");

   // a drag end comes with the left button up and no edge flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_drag |-> !rsp_buttons[0] && !rsp_left_press
         && !rsp_left_release && !rsp_right_press && !rsp_right_release)
      else $error("drag end with edge flags or left button down");

   // a release excludes every other edge
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_left_release || rsp_right_release) |->
         $countones({rsp_left_press, rsp_left_release,
                     rsp_right_press, rsp_right_release}) == 1)
      else $error("release reported with another edge");

endmodule

bind mouse_packet_cursor_tracker mpct_checker #(.COORD_BITS(COORD_BITS)) u_mpct_checker (.*);
